// ===== rtl/nsf_pkg.sv =====
// Shared types and constants of the NMEA sentence framer.
package nsf_pkg;

  // Field count cap; the count is also held to 31 by the 5-bit output.
  localparam int FIELD_COUNT_LIMIT = 31;
  localparam logic [5:0] FIELD_CAP =
    (FIELD_COUNT_LIMIT < 31) ? 6'(FIELD_COUNT_LIMIT) : 6'd31;

  // Sentence type codes
  localparam logic [3:0] TYPE_UNKNOWN = 4'd0;
  localparam int         NUM_TYPES    = 8;

  // Status codes
  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_MISMATCH  = 3'd1;
  localparam logic [2:0] STATUS_NOT_HEX   = 3'd2;
  localparam logic [2:0] STATUS_TOO_LONG  = 3'd3;
  localparam logic [2:0] STATUS_FEW_FIELD = 3'd4;
  localparam logic [2:0] STATUS_UNKNOWN   = 3'd5;

  // Known three-letter types, in type code order starting at code 1
  localparam logic [23:0] TYPE_NAMES [NUM_TYPES] = '{
    "GGA", "GLL", "GSA", "GSV", "RMC", "VTG", "ZDA", "TXT"
  };
  localparam logic [4:0] TYPE_MIN_FIELDS [NUM_TYPES] = '{
    5'd10, 5'd7, 5'd3, 5'd4, 5'd10, 5'd8, 5'd5, 5'd2
  };

  // One result item
  typedef struct packed {
    logic [3:0]  sentence_type;
    logic [15:0] talker_id;
    logic [2:0]  status;
    logic [4:0]  num_fields;
    logic [7:0]  computed_checksum;
    logic [7:0]  received_checksum;
  } result_t;

  // Decoded sentence type
  typedef struct packed {
    logic       known;
    logic [3:0] code;
    logic [4:0] min_fields;
  } type_info_t;

endpackage

// ===== rtl/nsf_type_decode.sv =====
// Sentence type lookup from the three type characters of the header.
module nsf_type_decode (
  input  logic [23:0]         type_chars,
  output nsf_pkg::type_info_t info
);

  // Compare against every known name; names are distinct
  always_comb begin
    info.known      = 1'b0;
    info.code       = nsf_pkg::TYPE_UNKNOWN;
    info.min_fields = 5'd0;
    for (int t = 0; t < nsf_pkg::NUM_TYPES; t++) begin
      if (type_chars == nsf_pkg::TYPE_NAMES[t]) begin
        info.known      = 1'b1;
        info.code       = 4'(t + 1);
        info.min_fields = nsf_pkg::TYPE_MIN_FIELDS[t];
      end
    end
  end

endmodule

// ===== rtl/nsf_parse_core.sv =====
// Per-byte sentence parser: phase, header, checksum and comma tracking.
module nsf_parse_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic [7:0]           rx_byte,
  input  logic [7:0]           max_length,
  output logic                 emit,
  output nsf_pkg::result_t     result
);

  typedef enum logic [1:0] {PH_HUNT, PH_BODY, PH_DIG1, PH_DIG2} phase_t;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [7:0]  hdr_r [5];
  logic [7:0]  hdr_nxt [5];
  logic [7:0]  xor_r, xor_nxt;
  logic        frozen_r, frozen_nxt;
  logic [4:0]  comma_r, comma_nxt;
  logic [3:0]  hi_r, hi_nxt;
  logic        derr_r, derr_nxt;

  logic [7:0]  lim;
  logic [8:0]  np;
  logic [8:0]  hdr_off;
  logic [5:0]  fields_full;
  logic [4:0]  fields;
  logic [3:0]  lo;
  logic [7:0]  rx_cs;
  nsf_pkg::type_info_t tinfo;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39)      v = c[3:0];
    else if (c >= 8'h41 && c <= 8'h46) v = c[3:0] + 4'd9;
    else if (c >= 8'h61 && c <= 8'h66) v = c[3:0] + 4'd9;
    hex_val = v;
  endfunction

  // Look up the type from header characters three to five
  nsf_type_decode u_type (
    .type_chars ({hdr_r[2], hdr_r[3], hdr_r[4]}),
    .info       (tinfo)
  );

  // Field count from commas, capped
  always_comb begin
    fields_full = {1'b0, comma_r} + 6'd1;
    if (fields_full > nsf_pkg::FIELD_CAP) fields = nsf_pkg::FIELD_CAP[4:0];
    else                                  fields = fields_full[4:0];
  end

  // Next state and result for the byte at the head of the pipe
  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    hdr_nxt    = hdr_r;
    xor_nxt    = xor_r;
    frozen_nxt = frozen_r;
    comma_nxt  = comma_r;
    hi_nxt     = hi_r;
    derr_nxt   = derr_r;
    emit       = 1'b0;

    lim     = (max_length < 8'd16) ? 8'd16 : max_length;
    np      = {1'b0, pos_r} + 9'd1;
    hdr_off = np - 9'd2;
    lo      = hex_val(rx_byte);
    rx_cs   = {hi_r, lo};

    result.sentence_type     = tinfo.code;
    result.talker_id         = {hdr_r[0], hdr_r[1]};
    result.status            = nsf_pkg::STATUS_OK;
    result.num_fields        = fields;
    result.computed_checksum = xor_r;
    result.received_checksum = 8'd0;

    priority if (rx_byte == CH_DOLLAR) begin
      // Start a new sentence
      pos_nxt    = 8'd1;
      hdr_nxt    = '{default: 8'd0};
      xor_nxt    = 8'd0;
      frozen_nxt = 1'b0;
      comma_nxt  = 5'd0;
      hi_nxt     = 4'd0;
      derr_nxt   = 1'b0;
      phase_nxt  = PH_BODY;
    end else if (phase_r == PH_HUNT) begin
      // Drop bytes outside a sentence
    end else if (np > {1'b0, lim}) begin
      // Over-long: report what was gathered and hunt again
      emit          = 1'b1;
      result.status = nsf_pkg::STATUS_TOO_LONG;
      phase_nxt     = PH_HUNT;
    end else begin
      pos_nxt = np[7:0];
      unique case (phase_r)
        PH_BODY: begin
          if (rx_byte == CH_STAR) begin
            phase_nxt = PH_DIG1;
          end else begin
            if (np >= 9'd2 && np <= 9'd6) hdr_nxt[hdr_off[2:0]] = rx_byte;
            if (rx_byte == CH_COMMA && comma_r != 5'd31) comma_nxt = comma_r + 5'd1;
            if (rx_byte == CH_CR || rx_byte == CH_LF) frozen_nxt = 1'b1;
            else if (!frozen_r) xor_nxt = xor_r ^ rx_byte;
          end
        end
        PH_DIG1: begin
          hi_nxt    = lo;
          derr_nxt  = !is_hex(rx_byte);
          phase_nxt = PH_DIG2;
        end
        PH_DIG2: begin
          emit                     = 1'b1;
          result.received_checksum = rx_cs;
          priority if (derr_r || !is_hex(rx_byte)) result.status = nsf_pkg::STATUS_NOT_HEX;
          else if (rx_cs != xor_r)                 result.status = nsf_pkg::STATUS_MISMATCH;
          else if (!tinfo.known)                   result.status = nsf_pkg::STATUS_UNKNOWN;
          else if (fields < tinfo.min_fields)      result.status = nsf_pkg::STATUS_FEW_FIELD;
          else                                     result.status = nsf_pkg::STATUS_OK;
          phase_nxt = PH_HUNT;
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end

    // Clear the sentence after any result
    if (emit) begin
      pos_nxt    = 8'd0;
      hdr_nxt    = '{default: 8'd0};
      xor_nxt    = 8'd0;
      frozen_nxt = 1'b0;
      comma_nxt  = 5'd0;
      hi_nxt     = 4'd0;
      derr_nxt   = 1'b0;
    end
  end

  // Hold parser state; advance on each processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      pos_r    <= 8'd0;
      hdr_r    <= '{default: 8'd0};
      xor_r    <= 8'd0;
      frozen_r <= 1'b0;
      comma_r  <= 5'd0;
      hi_r     <= 4'd0;
      derr_r   <= 1'b0;
    end else if (go) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      hdr_r    <= hdr_nxt;
      xor_r    <= xor_nxt;
      frozen_r <= frozen_nxt;
      comma_r  <= comma_nxt;
      hi_r     <= hi_nxt;
      derr_r   <= derr_nxt;
    end
  end

endmodule

// ===== rtl/nsf_sentence_framer_core.sv =====
// Top level of the NMEA sentence framer: input register, parser, result register.
//
// Usage:
//   Input channel in_valid/in_ready carries one received character (in_rx_byte)
//   per item. Output channel out_valid/out_ready carries one result per
//   checksummed or over-long sentence: type, talker, status, field count and
//   both checksums. Most characters produce no result.
//   cfg_wr_en/cfg_wr_data write max_length (reset 255, values below 16 act
//   as 16); write it only while no sentence is in flight.
//   A character accepted into the input register is parsed there once the
//   result register can take a result; its result (if any) is then loaded
//   into the output register, which drives out_valid.
//   Throughput: one character per cycle unless a result waits on out_ready,
//   set by the single parse pass between the input and result registers.
//   Stall: while a result waits on out_ready, the input register holds one
//   more character and in_ready drops once it is full.
//   Reset (rst_n low, synchronous): both registers empty, parser hunting for
//   a dollar sign, max_length back to 255.
module nmea_sentence_framer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_sentence_type,
  output logic [15:0] out_talker_id,
  output logic [2:0]  out_status,
  output logic [4:0]  out_num_fields,
  output logic [7:0]  out_computed_checksum,
  output logic [7:0]  out_received_checksum,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  logic             in_vld_r;
  logic [7:0]       in_byte_r;
  logic [7:0]       max_len_r;
  logic             out_vld_r;
  nsf_pkg::result_t out_r;
  logic             adv;
  logic             emit;
  nsf_pkg::result_t result;

  // Parse the held byte when the result register can take a result
  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  // Hold max_length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= 8'd255;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  nsf_parse_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (adv),
    .rx_byte    (in_byte_r),
    .max_length (max_len_r),
    .emit       (emit),
    .result     (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && emit) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_r <= result;
    end
  end

  assign out_valid             = out_vld_r;
  assign out_sentence_type     = out_r.sentence_type;
  assign out_talker_id         = out_r.talker_id;
  assign out_status            = out_r.status;
  assign out_num_fields        = out_r.num_fields;
  assign out_computed_checksum = out_r.computed_checksum;
  assign out_received_checksum = out_r.received_checksum;

endmodule
